[rtl/mrd_pkg.sv]
package mrd_pkg;

  localparam logic [3:0] KIND_PUBLISH  = 4'h3;
  localparam logic [3:0] KIND_SUBACK   = 4'h9;
  localparam logic [7:0] SUBACK_REJECT = 8'h80;

  typedef enum logic [2:0] {
    ROLE_HEADER     = 3'd0,
    ROLE_LENGTH     = 3'd1,
    ROLE_TOPIC_LEN  = 3'd2,
    ROLE_TOPIC      = 3'd3,
    ROLE_PACKET_ID  = 3'd4,
    ROLE_PAYLOAD    = 3'd5,
    ROLE_OTHER_BODY = 3'd6
  } role_t;

  typedef enum logic [2:0] {
    ST_OTHER        = 3'd0,
    ST_PUBLISH_OK   = 3'd1,
    ST_PUBLISH_SHORT = 3'd2,
    ST_SUBACK_OK    = 3'd3,
    ST_SUBACK_REJ   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    role_t      role;
    logic [3:0] kind;
    logic [1:0] qos;
    logic       last;
    status_t    status;
  } result_t;

endpackage

[rtl/mrd_in_reg.sv]
module mrd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

[rtl/mrd_parser.sv]
module mrd_parser import mrd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output result_t    res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [27:0] remaining_left, remaining_left_next;
  logic [1:0]  length_byte_index, length_byte_index_next;
  logic [3:0]  header_type, header_type_next;
  logic [1:0]  header_qos, header_qos_next;
  logic [15:0] topic_length, topic_length_next;
  logic [27:0] body_index, body_index_next;
  logic [7:0]  suback_seen_code, suback_seen_code_next;

  logic [27:0] group_val;
  logic [27:0] len_sum;
  logic [27:0] rem_dec;
  logic [27:0] total;
  logic [27:0] tl_ext;
  logic        last_len;

  function automatic status_t finish(input logic [3:0] kind, input logic [27:0] tot,
                                     input logic [27:0] tl, input logic [7:0] code);
    status_t st;
    st = ST_OTHER;
    if (kind == KIND_PUBLISH) begin
      st = (tot >= 28'd2 && tot >= tl + 28'd2) ? ST_PUBLISH_OK : ST_PUBLISH_SHORT;
    end else if (kind == KIND_SUBACK && tot >= 28'd3) begin
      st = (code == SUBACK_REJECT) ? ST_SUBACK_REJ : ST_SUBACK_OK;
    end
    return st;
  endfunction

  always_comb begin
    phase_next             = phase;
    remaining_left_next    = remaining_left;
    length_byte_index_next = length_byte_index;
    header_type_next       = header_type;
    header_qos_next        = header_qos;
    topic_length_next      = topic_length;
    body_index_next        = body_index;
    suback_seen_code_next  = suback_seen_code;

    case (length_byte_index)
      2'd0:    group_val = {21'd0, rx_byte[6:0]};
      2'd1:    group_val = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    group_val = {7'd0, rx_byte[6:0], 14'd0};
      default: group_val = {rx_byte[6:0], 21'd0};
    endcase
    len_sum  = remaining_left + group_val;
    last_len = !rx_byte[7] ||
               (({1'b0, length_byte_index} + 3'd1) >= 3'(MAX_LENGTH_BYTES));
    rem_dec  = remaining_left - 28'd1;
    total    = body_index + 28'd1;
    tl_ext   = {12'd0, topic_length};

    res.data   = rx_byte;
    res.role   = ROLE_OTHER_BODY;
    res.kind   = header_type;
    res.qos    = header_qos;
    res.last   = 1'b0;
    res.status = ST_OTHER;

    unique case (phase)
      PH_HEADER: begin
        header_type_next       = rx_byte[7:4];
        header_qos_next        = rx_byte[2:1];
        remaining_left_next    = '0;
        length_byte_index_next = '0;
        topic_length_next      = '0;
        body_index_next        = '0;
        suback_seen_code_next  = '0;
        phase_next             = PH_LENGTH;
        res.role               = ROLE_HEADER;
        res.kind               = rx_byte[7:4];
        res.qos                = rx_byte[2:1];
      end
      PH_LENGTH: begin
        res.role            = ROLE_LENGTH;
        remaining_left_next = len_sum;
        if (last_len) begin
          length_byte_index_next = '0;
          body_index_next        = '0;
          if (len_sum == '0) begin
            res.last   = 1'b1;
            res.status = finish(header_type, 28'd0, tl_ext, suback_seen_code);
            phase_next = PH_HEADER;
          end else begin
            phase_next = PH_BODY;
          end
        end else begin
          length_byte_index_next = length_byte_index + 2'd1;
        end
      end
      PH_BODY: begin
        if (header_type == KIND_PUBLISH) begin
          if (body_index == 28'd0) begin
            topic_length_next = {rx_byte, 8'h00};
            res.role          = ROLE_TOPIC_LEN;
          end else if (body_index == 28'd1) begin
            topic_length_next = {topic_length[15:8], rx_byte};
            res.role          = ROLE_TOPIC_LEN;
          end else if (body_index < tl_ext + 28'd2) begin
            res.role = ROLE_TOPIC;
          end else if (header_qos != 2'd0 && body_index < tl_ext + 28'd4) begin
            res.role = ROLE_PACKET_ID;
          end else begin
            res.role = ROLE_PAYLOAD;
          end
        end else if (header_type == KIND_SUBACK && body_index == 28'd2) begin
          suback_seen_code_next = rx_byte;
        end
        body_index_next     = total;
        remaining_left_next = rem_dec;
        if (rem_dec == '0) begin
          res.last   = 1'b1;
          res.status = finish(header_type, total, {12'd0, topic_length_next},
                              suback_seen_code_next);
          phase_next = PH_HEADER;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      remaining_left    <= '0;
      length_byte_index <= '0;
      header_type       <= '0;
      header_qos        <= '0;
      topic_length      <= '0;
      body_index        <= '0;
      suback_seen_code  <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      remaining_left    <= remaining_left_next;
      length_byte_index <= length_byte_index_next;
      header_type       <= header_type_next;
      header_qos        <= header_qos_next;
      topic_length      <= topic_length_next;
      body_index        <= body_index_next;
      suback_seen_code  <= suback_seen_code_next;
    end
  end

endmodule

[rtl/mrd_out_reg.sv]
module mrd_out_reg import mrd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    can_load,
  output result_t res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/mqtt_receive_deframer.sv]
// MQTT receive deframer: tags each received byte with its role in the packet.
// Path: an accepted byte goes through the input register, then parse logic
//   into the result register.
// Throughput: one item per cycle while out_ready keeps the output draining;
//   set by the single parse pass.
// Reset: synchronous, active high; clears both valid flags and the parse state,
//   which then waits for a fixed header byte.
module mqtt_receive_deframer import mrd_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [2:0] byte_role,
  output logic [3:0] packet_kind,
  output logic [1:0] qos_level,
  output logic       packet_end,
  output logic [2:0] end_status
);

  // Stage 1: held input byte.
  logic       held_valid;
  logic [7:0] held_byte;
  // Parse result and registered copy.
  result_t    res_comb;
  result_t    res_q;
  logic       can_load;
  logic       advance;

  // A held item moves on whenever the result register is free or being
  // drained this cycle; parse state only updates on that move.
  assign advance = held_valid && can_load;

  mrd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Header / varint length / body tracking, one byte per pass.
  mrd_parser #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .rx_byte (held_byte),
    .res     (res_comb)
  );

  mrd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res_in    (res_comb),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  assign data_byte   = res_q.data;
  assign byte_role   = res_q.role;
  assign packet_kind = res_q.kind;
  assign qos_level   = res_q.qos;
  assign packet_end  = res_q.last;
  assign end_status  = res_q.status;

endmodule

[rtl/mrd_checker.sv]
module mrd_checker import mrd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic [2:0] byte_role,
  input logic [3:0] packet_kind,
  input logic [1:0] qos_level,
  input logic       packet_end,
  input logic [2:0] end_status
);

  logic       expect_header;
  logic       after_header;
  logic [3:0] kind_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      after_header  <= 1'b0;
      kind_seen     <= '0;
    end else if (out_valid && out_ready) begin
      expect_header <= packet_end;
      after_header  <= (byte_role == ROLE_HEADER);
      if (byte_role == ROLE_HEADER) begin
        kind_seen <= packet_kind;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_role)
      && $stable(packet_kind) && $stable(qos_level)
      && $stable(packet_end) && $stable(end_status))
    else $error("result changed while stalled");

  a_first_is_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && expect_header |-> byte_role == ROLE_HEADER)
    else $error("packet does not start with a header item");

  a_length_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && after_header |-> byte_role == ROLE_LENGTH)
    else $error("header not followed by a length item");

  a_kind_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !expect_header |-> packet_kind == kind_seen)
    else $error("packet kind changed inside a packet");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind mqtt_receive_deframer mrd_checker u_chk (.*);
